[hw/rtl/b64lw_pkg.sv]
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the alphabet lookup for the line-wrapped
// Base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam int          QUEUE_DEPTH_DEF  = 4;
  localparam logic [7:0]  LINE_LIMIT_RESET = 8'd76;

  localparam logic [7:0]  CHAR_PAD = 8'h3D;
  localparam logic [7:0]  CHAR_CR  = 8'h0D;
  localparam logic [7:0]  CHAR_LF  = 8'h0A;

  // job kinds
  localparam logic [1:0]  KIND_GROUP      = 2'd0;
  localparam logic [1:0]  KIND_GROUP_CRLF = 2'd1;
  localparam logic [1:0]  KIND_TAIL1      = 2'd2;
  localparam logic [1:0]  KIND_TAIL2      = 2'd3;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  kind;
    logic        last;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[hw/rtl/b64lw_front.sv]
// ----------------------------------------------------------------------------
// b64lw_front
// Accepts input bytes, assembles groups, tracks the line count and posts
// one job per finished group or message tail.
// ----------------------------------------------------------------------------
module b64lw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              line_limit_we,
  input  logic [7:0]        line_limit_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              queue_full,
  output logic              push,
  output b64lw_pkg::job_t   push_job
);
  import b64lw_pkg::*;

  logic [7:0]  line_limit;
  logic [15:0] held_bytes;
  logic [1:0]  group_fill;
  logic [7:0]  line_count;
  logic [8:0]  count_sum;
  logic        wrap;
  logic        accept;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign count_sum = {1'b0, line_count} + 9'd4;
  assign wrap      = count_sum >= {1'b0, line_limit};

  always_comb begin
    push_job.last = in_last;
    push_job.word = {held_bytes, in_byte};
    push_job.kind = wrap ? KIND_GROUP_CRLF : KIND_GROUP;
    push          = 1'b0;
    if (group_fill == 2'd2) begin
      push = accept;
    end else if (in_last) begin
      push = accept;
      if (group_fill == 2'd0) begin
        push_job.word = {in_byte, 16'h0000};
        push_job.kind = KIND_TAIL1;
      end else begin
        push_job.word = {held_bytes[7:0], in_byte, 8'h00};
        push_job.kind = KIND_TAIL2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
      held_bytes <= '0;
      group_fill <= '0;
      line_count <= '0;
    end else begin
      if (line_limit_we) begin
        line_limit <= line_limit_wdata;
      end
      if (accept) begin
        if (in_last) begin
          held_bytes <= '0;
          group_fill <= '0;
          line_count <= '0;
        end else if (group_fill == 2'd2) begin
          held_bytes <= '0;
          group_fill <= '0;
          line_count <= wrap ? 8'd0 : count_sum[7:0];
        end else begin
          held_bytes <= {held_bytes[7:0], in_byte};
          group_fill <= group_fill + 2'd1;
        end
      end
    end
  end

endmodule

[hw/rtl/b64lw_queue.sv]
// ----------------------------------------------------------------------------
// b64lw_queue
// Small register queue of jobs between the front and the back end, with the
// head visible without a read delay.
// ----------------------------------------------------------------------------
module b64lw_queue #(
  parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  b64lw_pkg::queue_ctrl_t  ctrl,
  input  b64lw_pkg::job_t         push_job,
  output b64lw_pkg::job_t         head_job,
  output logic                    full,
  output logic                    empty
);
  import b64lw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = ctrl.push && !full;
  assign do_pop   = ctrl.pop && !empty;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/b64lw_back.sv]
// ----------------------------------------------------------------------------
// b64lw_back
// Serializes the job at the queue head into characters, one per cycle while
// out_ready allows and the queue is not empty, into a registered output stage.
// ----------------------------------------------------------------------------
module b64lw_back (
  input  logic              clk,
  input  logic              rst,
  input  b64lw_pkg::job_t   head_job,
  input  logic              queue_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              run_last,
  output logic              stream_end
);
  import b64lw_pkg::*;

  logic [2:0] idx;
  logic [2:0] final_idx;
  logic       is_final;
  logic       fire;
  logic [5:0] sext;
  logic [7:0] char_next;

  assign final_idx = (head_job.kind == KIND_GROUP_CRLF) ? 3'd5 : 3'd3;
  assign is_final  = idx == final_idx;
  assign fire      = (!out_valid || out_ready) && !queue_empty;
  assign pop       = fire && is_final;

  always_comb begin
    case (idx[1:0])
      2'd0:    sext = head_job.word[23:18];
      2'd1:    sext = head_job.word[17:12];
      2'd2:    sext = head_job.word[11:6];
      default: sext = head_job.word[5:0];
    endcase
    case (idx)
      3'd2:    char_next = (head_job.kind == KIND_TAIL1) ? CHAR_PAD : b64_char(sext);
      3'd3:    char_next = (head_job.kind == KIND_TAIL1 || head_job.kind == KIND_TAIL2)
                           ? CHAR_PAD : b64_char(sext);
      3'd4:    char_next = CHAR_CR;
      3'd5:    char_next = CHAR_LF;
      default: char_next = b64_char(sext);
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char   <= char_next;
      run_last   <= is_final;
      stream_end <= is_final && head_job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        idx       <= is_final ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/base64_encoder_line_wrapped.sv]
// ----------------------------------------------------------------------------
// base64_encoder_line_wrapped
// Base64 encoder with CR LF line wrapping and '=' padding of the message tail.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while the job queue has room; every third byte,
// and the last byte of a message, posts a job of four or six characters
// (six when CR LF follows). The output stage sends one character per cycle
// while the sink is ready and a job is queued, so sustained input is limited
// by that output serializer. A group's job passes through the queue entry
// register and then the registered output stage. line_limit takes effect for
// the next byte; the user must write it only while the encoder is idle, and
// the block itself does not enforce this.
module base64_encoder_line_wrapped #(
  parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_limit_we,
  input  logic [7:0] line_limit_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // stream_end
);
  import b64lw_pkg::*;

  job_t        push_job;
  job_t        head_job;
  queue_ctrl_t qctrl;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  assign qctrl = '{push: q_push, pop: q_pop};

  b64lw_front u_front (
    .clk              (clk),
    .rst              (rst),
    .line_limit_we    (line_limit_we),
    .line_limit_wdata (line_limit_wdata),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_byte          (s_axis_tdata),
    .in_last          (s_axis_tlast),
    .queue_full       (q_full),
    .push             (q_push),
    .push_job         (push_job)
  );

  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (qctrl),
    .push_job (push_job),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64lw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .queue_empty (q_empty),
    .pop         (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_char    (m_axis_tdata),
    .run_last    (m_axis_tlast),
    .stream_end  (m_axis_tuser)
  );

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end without run last");

  a_job_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a job");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tdata == CHAR_CR
    |=> m_axis_tvalid && m_axis_tdata == CHAR_LF)
    else $error("CR not followed by LF");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_axis_tready)
    else $error("input taken while queue full");

endmodule
